/* sv/assert_macros.svh */
// Assertion macros shared by the change detector RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property every clock while out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* sv/dicd_pkg.sv */
// Types, codes and constants of the digital input change detector.
// No dependencies; used by scoped names in every module but dicd_fifo.
`default_nettype none
package dicd_pkg;

	localparam int WORD_BITS   = 16;
	localparam int WORD_DEPTH  = 256;
	localparam int POINT_COUNT = 4096;

	localparam logic [1:0] MODE_FAULT  = 2'd0;
	localparam logic [1:0] MODE_FORCE  = 2'd1;
	localparam logic [1:0] MODE_STATE  = 2'd2;
	localparam logic [1:0] MODE_COMMIT = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  word_index;
		logic [15:0] state_bits;
		logic [15:0] force_bits;
		logic [15:0] fault_bits;
		logic [15:0] scan_bits;
		logic [15:0] range_mask;
	} in_item_t;

	typedef struct packed {
		logic [11:0] point_no;
		logic [1:0]  event_kind;
		logic        live_state;
		logic        fault_flag;
		logic        man_set;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  word_index;
		logic [15:0] state_bits;
		logic [15:0] force_bits;
		logic [15:0] fault_bits;
		logic [15:0] hit;
	} work_t;

	typedef struct packed {
		logic [15:0] state_bits;
		logic [15:0] force_bits;
		logic [15:0] fault_bits;
	} image_t;

	// points of a word whose number lies below POINT_COUNT
	function automatic logic [15:0] point_mask(input logic [7:0] word_index);
		logic [15:0] m;
		m = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			m[b] = ({5'd0, word_index, 4'(b)} < 17'(POINT_COUNT));
		end
		return m;
	endfunction

endpackage
`default_nettype wire

/* sv/dicd_fifo.sv */
// Two-entry queue of any packed type, used as the work and result queues.
// Depends on nothing but the item type given as a parameter.
`default_nettype none
module dicd_fifo #(
	parameter type T = logic
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire T     din,
	input  wire logic pop,
	output logic      empty,
	output T          dout
);

	T           mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/dicd_front.sv */
// Front end: accepts words, keeps the previous images and classifies changes.
// Depends on dicd_pkg; feeds the work queue with words that carry events.
`default_nettype none
module dicd_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire dicd_pkg::in_item_t sample,
	output logic                    wq_push,
	input  wire logic               wq_full,
	output dicd_pkg::work_t         wq_data
);

	dicd_pkg::image_t   prev_mem [dicd_pkg::WORD_DEPTH];
	logic [255:0]       valid_q;
	dicd_pkg::in_item_t item_s1;
	dicd_pkg::image_t   rd_data_s1;
	logic               rd_valid_s1;
	logic               vld_s1;

	dicd_pkg::image_t   prev;
	logic               accept;
	logic               advance;
	logic               produces;
	logic [15:0]        ds;
	logic [15:0]        dm;
	logic [15:0]        df;
	logic [15:0]        sel;
	logic [15:0]        hit;

	assign accept = push && !full;

	always_ff @(posedge clk) begin
		if (accept && sample.mode == dicd_pkg::MODE_COMMIT) begin
			prev_mem[sample.word_index] <= '{sample.state_bits, sample.force_bits,
				sample.fault_bits};
		end
		if (accept) begin
			rd_data_s1 <= prev_mem[sample.word_index];
			item_s1    <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			if (accept && sample.mode == dicd_pkg::MODE_COMMIT) begin
				valid_q[sample.word_index] <= 1'b1;
			end
			if (accept) begin
				rd_valid_s1 <= valid_q[sample.word_index];
			end
			if (advance) begin
				vld_s1 <= accept;
			end
		end
	end

	always_comb begin
		prev = rd_valid_s1 ? rd_data_s1 : '0;
		ds   = item_s1.state_bits ^ prev.state_bits;
		dm   = item_s1.force_bits ^ prev.force_bits;
		df   = item_s1.fault_bits ^ prev.fault_bits;
		unique case (item_s1.mode)
			dicd_pkg::MODE_FAULT: sel = df;
			dicd_pkg::MODE_FORCE: sel = dm;
			dicd_pkg::MODE_STATE: sel = ds & ~dm & ~df;
			default:              sel = '0;
		endcase
		hit = sel & item_s1.scan_bits & item_s1.range_mask
			& dicd_pkg::point_mask(item_s1.word_index);
	end

	assign produces = vld_s1 && item_s1.mode != dicd_pkg::MODE_COMMIT && hit != '0;
	assign advance  = !vld_s1 || !produces || !wq_full;
	assign full     = !advance;
	assign wq_push  = produces && !wq_full;

	assign wq_data.mode       = item_s1.mode;
	assign wq_data.word_index = item_s1.word_index;
	assign wq_data.state_bits = item_s1.state_bits;
	assign wq_data.force_bits = item_s1.force_bits;
	assign wq_data.fault_bits = item_s1.fault_bits;
	assign wq_data.hit        = hit;

endmodule
`default_nettype wire

/* sv/dicd_back.sv */
// Back end: walks the changed points of a queued word, lowest point first.
// Depends on dicd_pkg; emits one event per cycle while a word waits and the result queue has room.
`default_nettype none
module dicd_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wq_empty,
	output logic                 wq_pop,
	input  wire dicd_pkg::work_t work,
	output logic                 oq_push,
	input  wire logic            oq_full,
	output dicd_pkg::out_item_t  oq_data
);

	logic [15:0] done_q;
	logic [15:0] remain;
	logic [15:0] lsb;
	logic [3:0]  bit_idx;
	logic        is_last;
	logic        fire;

	always_comb begin
		remain  = work.hit & ~done_q;
		lsb     = remain & (~remain + 16'd1);
		bit_idx = '0;
		for (int i = 0; i < dicd_pkg::WORD_BITS; i++) begin
			if (lsb[i]) begin
				bit_idx = bit_idx | 4'(i);
			end
		end
		is_last = (remain & ~lsb) == '0;
	end

	assign fire    = !wq_empty && !oq_full;
	assign oq_push = fire;
	assign wq_pop  = fire && is_last;

	assign oq_data.point_no   = {work.word_index, bit_idx};
	assign oq_data.event_kind = work.mode;
	assign oq_data.live_state = work.state_bits[bit_idx];
	assign oq_data.fault_flag = work.fault_bits[bit_idx];
	assign oq_data.man_set    = work.force_bits[bit_idx];
	assign oq_data.last       = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (fire) begin
			done_q <= is_last ? '0 : (done_q | lsb);
		end
	end

endmodule
`default_nettype wire

/* sv/digital_input_change_detector.sv */
// Digital input change detector: front end, work queue, back end, result queue.
// Depends on dicd_pkg, dicd_fifo, dicd_front, dicd_back and assert_macros.svh.
//
// Usage:
//   Input channel: drive sample and push; a word is taken on a clock edge with
//   push high and full low. Mode selects the fault, force or state-change pass,
//   or the commit that stores the current words as the previous images.
//   Result channel: while empty is low, report holds the oldest event; pop with
//   empty low takes it. Events come in ascending point order, last marking the
//   final event of a word. Commits and words with no changed point give none.
//   A word passes the front-end register and the work queue, and its events
//   the result queue, before they show on report. The back end emits one
//   event per cycle while the result queue has room. A word is taken every
//   cycle while the work queue has room.
//   Reset: all previous images read as zero (one valid bit per word index),
//   all queues empty; no clearing pass is needed.
//   Stall: with pop low the result queue fills, then the work queue, then full
//   rises; nothing is dropped.
`default_nettype none
`include "assert_macros.svh"
module digital_input_change_detector (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire dicd_pkg::in_item_t sample,
	output logic                    empty,
	input  wire logic               pop,
	output dicd_pkg::out_item_t     report
);

	logic                wq_push;
	logic                wq_full;
	logic                wq_pop;
	logic                wq_empty;
	dicd_pkg::work_t     wq_din;
	dicd_pkg::work_t     wq_head;
	logic                oq_push;
	logic                oq_full;
	dicd_pkg::out_item_t oq_din;

	dicd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.sample  (sample),
		.wq_push (wq_push),
		.wq_full (wq_full),
		.wq_data (wq_din)
	);

	dicd_fifo #(.T(dicd_pkg::work_t)) u_workq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (wq_push),
		.full   (wq_full),
		.din    (wq_din),
		.pop    (wq_pop),
		.empty  (wq_empty),
		.dout   (wq_head)
	);

	dicd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wq_empty (wq_empty),
		.wq_pop   (wq_pop),
		.work     (wq_head),
		.oq_push  (oq_push),
		.oq_full  (oq_full),
		.oq_data  (oq_din)
	);

	dicd_fifo #(.T(dicd_pkg::out_item_t)) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.full   (oq_full),
		.din    (oq_din),
		.pop    (pop),
		.empty  (empty),
		.dout   (report)
	);

	`ASSERT_IMPLIES(a_head_has_hit, clk, arst_n, !wq_empty, wq_head.hit != 16'd0,
		"queued word carries no event")
	`ASSERT_IMPLIES(a_no_commit_event, clk, arst_n, oq_push,
		oq_din.event_kind != dicd_pkg::MODE_COMMIT, "event emitted for a commit")
	`ASSERT_IMPLIES(a_point_in_range, clk, arst_n, oq_push,
		32'(oq_din.point_no) < dicd_pkg::POINT_COUNT, "point beyond count")

endmodule
`default_nettype wire
